// File: sv/lcdn_pkg.sv
// Package for the LCD nibble write sequencer.
// Holds the control word types, the microcode table and the power-up tables.
// No dependencies.
package lcdn_pkg;

  localparam int INIT_COMMANDS = 6;
  localparam int INIT_TABLE_LEN = 6;
  localparam int INIT_COUNT = (INIT_COMMANDS > INIT_TABLE_LEN) ? INIT_TABLE_LEN : INIT_COMMANDS;

  localparam logic [16:0] IDLE_HOLD = 17'd3200;
  localparam logic [7:0] LINE_TWO_CMD = 8'hC0;
  localparam logic [6:0] COUNT_MAX = 7'd127;

  localparam logic [15:0] PULSE_RESET = 16'd25;
  localparam logic [15:0] SETTLE_RESET = 16'd1000;
  localparam logic [6:0] LINE_LEN_RESET = 7'd16;

  typedef enum logic [1:0] {
    MODE_COMMAND = 2'd0,
    MODE_CHAR = 2'd1,
    MODE_POWER = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_PULSE = 2'd0,
    REG_SETTLE = 2'd1,
    REG_LINE_LEN = 2'd2,
    REG_SPARE = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    NIB_ZERO,
    NIB_HIGH,
    NIB_LOW
  } nib_sel_t;

  typedef enum logic [1:0] {
    HOLD_ZERO,
    HOLD_PULSE,
    HOLD_SETTLE,
    HOLD_IDLE
  } hold_sel_t;

  typedef enum logic {
    JUMP_NEXT,
    JUMP_BYTE_END
  } jump_t;

  typedef struct packed {
    nib_sel_t nib;
    logic en;
    hold_sel_t hold;
    jump_t jump;
  } ucode_t;

  typedef struct packed {
    logic go;
    logic power;
    logic rs;
    logic line_two;
    logic [7:0] byte_val;
  } start_t;

  localparam logic [2:0] PC_IDLE = 3'd0;
  localparam logic [2:0] PC_BYTE = 3'd1;

  // Step 0 is the power-up idle phase; steps 1 to 6 send one byte.
  function automatic ucode_t ucode(input logic [2:0] pc);
    ucode_t w;
    case (pc)
      3'd0: w = '{NIB_ZERO, 1'b0, HOLD_IDLE, JUMP_NEXT};
      3'd1: w = '{NIB_HIGH, 1'b0, HOLD_ZERO, JUMP_NEXT};
      3'd2: w = '{NIB_HIGH, 1'b1, HOLD_PULSE, JUMP_NEXT};
      3'd3: w = '{NIB_HIGH, 1'b0, HOLD_ZERO, JUMP_NEXT};
      3'd4: w = '{NIB_LOW, 1'b0, HOLD_ZERO, JUMP_NEXT};
      3'd5: w = '{NIB_LOW, 1'b1, HOLD_PULSE, JUMP_NEXT};
      3'd6: w = '{NIB_LOW, 1'b0, HOLD_SETTLE, JUMP_BYTE_END};
      default: w = '{NIB_ZERO, 1'b0, HOLD_ZERO, JUMP_BYTE_END};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] power_cmd(input logic [2:0] step);
    logic [7:0] c;
    case (step)
      3'd0: c = 8'h33;
      3'd1: c = 8'h32;
      3'd2: c = 8'h28;
      3'd3: c = 8'h0C;
      3'd4: c = 8'h06;
      3'd5: c = 8'h01;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [14:0] power_wait(input logic [2:0] step);
    logic [14:0] t;
    case (step)
      3'd0: t = 15'd30000;
      3'd1: t = 15'd30000;
      3'd2: t = 15'd30000;
      3'd3: t = 15'd800;
      3'd4: t = 15'd800;
      3'd5: t = 15'd10000;
      default: t = 15'd0;
    endcase
    return t;
  endfunction

endpackage

// File: sv/lcd_nibble_write_sequencer.sv
// Top level of the LCD nibble write sequencer: configuration registers,
// character count and input word decode. Depends on lcdn_pkg and lcdn_sequencer.
// An accepted word first loads the sequencer state; the first pin phase is then registered from it.
// Throughput: one phase per cycle when unstalled; 6 phases for a byte, 12 when the
// line-two command follows, 37 for power-up; a new word stalls until the last phase is registered.
// Mode 3 words are taken and produce nothing. Synchronous reset restores the
// register defaults and clears the character count and sequencer state.
module lcd_nibble_write_sequencer (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  logic [1:0] mode,
  input  logic [7:0] byte_value,
  input  logic text_start,
  output logic pin_valid,
  input  logic pin_stall,
  output logic [3:0] nibble,
  output logic reg_select,
  output logic enable,
  output logic [16:0] hold_ticks,
  output logic last
);
  import lcdn_pkg::*;

  logic [15:0] enable_pulse_ticks;
  logic [15:0] byte_settle_ticks;
  logic [6:0] line_length;
  logic [6:0] char_count;
  logic [6:0] char_count_next;
  logic [6:0] count_base;
  logic busy;
  logic accept;
  start_t start;

  always_comb begin
    accept = cmd_valid && !busy;
    count_base = text_start ? 7'd0 : char_count;
    char_count_next = (count_base < COUNT_MAX) ? count_base + 7'd1 : count_base;
    start.go = accept && (mode != MODE_NONE);
    start.power = (mode == MODE_POWER);
    start.rs = (mode == MODE_CHAR);
    start.line_two = (mode == MODE_CHAR) && (char_count_next == line_length);
    start.byte_val = byte_value;
  end

  assign cmd_stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_pulse_ticks <= PULSE_RESET;
      byte_settle_ticks <= SETTLE_RESET;
      line_length <= LINE_LEN_RESET;
      char_count <= 7'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PULSE: enable_pulse_ticks <= cfg_data;
          REG_SETTLE: byte_settle_ticks <= cfg_data;
          REG_LINE_LEN: line_length <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (accept && (mode == MODE_CHAR)) begin
        char_count <= char_count_next;
      end
    end
  end

  lcdn_sequencer u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .enable_pulse_ticks(enable_pulse_ticks),
    .byte_settle_ticks(byte_settle_ticks),
    .busy(busy),
    .pin_valid(pin_valid),
    .pin_stall(pin_stall),
    .nibble(nibble),
    .reg_select(reg_select),
    .enable(enable),
    .hold_ticks(hold_ticks),
    .last(last)
  );

endmodule

// File: sv/lcdn_sequencer.sv
// Microcoded phase sequencer: step counter, byte datapath and output word register.
// Depends on lcdn_pkg for the control word table and power-up tables.
module lcdn_sequencer (
  input  logic clk,
  input  logic rst,
  input  lcdn_pkg::start_t start,
  input  logic [15:0] enable_pulse_ticks,
  input  logic [15:0] byte_settle_ticks,
  output logic busy,
  output logic pin_valid,
  input  logic pin_stall,
  output logic [3:0] nibble,
  output logic reg_select,
  output logic enable,
  output logic [16:0] hold_ticks,
  output logic last
);
  import lcdn_pkg::*;

  logic [2:0] pc;
  logic [2:0] init_step;
  logic [7:0] byte_val;
  logic rs;
  logic power;
  logic line_two;

  ucode_t ctrl;
  logic advance;
  logic more;
  logic [14:0] extra;
  logic [3:0] nib_next;
  logic [16:0] hold_next;
  logic last_next;

  always_comb begin
    ctrl = ucode(pc);
    advance = busy && (!pin_valid || !pin_stall);
    more = power ? (init_step != 3'(INIT_COUNT - 1)) : line_two;
    extra = power ? power_wait(init_step) : 15'd0;
    case (ctrl.nib)
      NIB_HIGH: nib_next = byte_val[7:4];
      NIB_LOW: nib_next = byte_val[3:0];
      default: nib_next = 4'd0;
    endcase
    case (ctrl.hold)
      HOLD_PULSE: hold_next = {1'b0, enable_pulse_ticks};
      HOLD_SETTLE: hold_next = {1'b0, byte_settle_ticks} + {2'b00, extra};
      HOLD_IDLE: hold_next = IDLE_HOLD;
      default: hold_next = 17'd0;
    endcase
    last_next = (ctrl.jump == JUMP_BYTE_END) && !more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pin_valid <= 1'b0;
      pc <= PC_IDLE;
      init_step <= 3'd0;
      line_two <= 1'b0;
      power <= 1'b0;
    end else begin
      if (advance) begin
        pin_valid <= 1'b1;
        nibble <= nib_next;
        reg_select <= rs;
        enable <= ctrl.en;
        hold_ticks <= hold_next;
        last <= last_next;
        if (ctrl.jump == JUMP_NEXT) begin
          pc <= pc + 3'd1;
        end else if (more) begin
          pc <= PC_BYTE;
          if (power) begin
            init_step <= init_step + 3'd1;
            byte_val <= power_cmd(init_step + 3'd1);
          end else begin
            line_two <= 1'b0;
            byte_val <= LINE_TWO_CMD;
            rs <= 1'b0;
          end
        end else begin
          busy <= 1'b0;
          init_step <= 3'd0;
        end
      end else if (!pin_stall) begin
        pin_valid <= 1'b0;
      end
      if (start.go) begin
        busy <= 1'b1;
        pc <= start.power ? PC_IDLE : PC_BYTE;
        power <= start.power;
        rs <= start.rs;
        line_two <= start.line_two;
        init_step <= 3'd0;
        byte_val <= start.power ? power_cmd(3'd0) : start.byte_val;
      end
    end
  end

endmodule

// File: tb/lcd_nibble_write_sequencer_tb.sv
// Self-checking testbench for the LCD nibble write sequencer: a queue-fed word driver,
// a pin phase monitor and a predictor of the expected phases, over several sender idle and receiver stall settings.
// Depends on lcdn_pkg and lcd_nibble_write_sequencer.
module lcd_nibble_write_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdn_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_WORDS = 18;
  localparam logic [47:0] POWER_BYTES = 48'h33_32_28_0C_06_01;
  localparam logic [89:0] POWER_WAITS = {15'd30000, 15'd30000, 15'd30000,
                                         15'd800, 15'd800, 15'd10000};

  typedef struct packed {
    logic [3:0] nib;
    logic rs;
    logic en;
    logic [16:0] hold;
    logic last;
  } pin_phase_t;

  typedef struct packed {
    mode_t mode;
    logic [7:0] value;
    logic start;
  } lcd_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_PULSE;
  logic [15:0] cfg_data = 16'd0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [1:0] mode = MODE_COMMAND;
  logic [7:0] byte_value = 8'd0;
  logic text_start = 1'b0;
  logic pin_valid;
  logic pin_stall = 1'b0;
  logic [3:0] nibble;
  logic reg_select;
  logic enable;
  logic [16:0] hold_ticks;
  logic last;

  lcd_word_t words_to_send[$];
  pin_phase_t pin_phases_due[$];
  logic [15:0] pulse_cfg = PULSE_RESET;
  logic [15:0] settle_cfg = SETTLE_RESET;
  logic [6:0] line_len_cfg = LINE_LEN_RESET;
  logic [6:0] text_chars = 7'd0;
  int phases_left = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  lcd_nibble_write_sequencer dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .mode(mode),
    .byte_value(byte_value),
    .text_start(text_start),
    .pin_valid(pin_valid),
    .pin_stall(pin_stall),
    .nibble(nibble),
    .reg_select(reg_select),
    .enable(enable),
    .hold_ticks(hold_ticks),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_phase(logic [3:0] nib, logic rs, logic en, logic [16:0] hold);
    pin_phases_due.push_back('{nib, rs, en, hold, phases_left == 1});
    phases_left--;
  endfunction

  function automatic void queue_byte(logic [7:0] value, logic rs, logic [16:0] final_hold);
    queue_phase(value[7:4], rs, 1'b0, 17'd0);
    queue_phase(value[7:4], rs, 1'b1, {1'b0, pulse_cfg});
    queue_phase(value[7:4], rs, 1'b0, 17'd0);
    queue_phase(value[3:0], rs, 1'b0, 17'd0);
    queue_phase(value[3:0], rs, 1'b1, {1'b0, pulse_cfg});
    queue_phase(value[3:0], rs, 1'b0, final_hold);
  endfunction

  function automatic void predict_word(lcd_word_t w);
    logic line_two;
    case (w.mode)
      MODE_COMMAND: begin
        phases_left = 6;
        queue_byte(w.value, 1'b0, {1'b0, settle_cfg});
      end
      MODE_CHAR: begin
        if (w.start) text_chars = 7'd0;
        if (text_chars != COUNT_MAX) text_chars++;
        line_two = (text_chars == line_len_cfg);
        phases_left = line_two ? 12 : 6;
        queue_byte(w.value, 1'b1, {1'b0, settle_cfg});
        if (line_two) queue_byte(LINE_TWO_CMD, 1'b0, {1'b0, settle_cfg});
      end
      MODE_POWER: begin
        phases_left = 1 + 6 * INIT_COUNT;
        queue_phase(4'd0, 1'b0, 1'b0, IDLE_HOLD);
        for (int i = 0; i < INIT_COUNT; i++)
          queue_byte(POWER_BYTES[47 - 8 * i -: 8], 1'b0,
                     {1'b0, settle_cfg} + {2'b00, POWER_WAITS[89 - 15 * i -: 15]});
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : driver
    lcd_word_t w;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        w = words_to_send.pop_front();
        predict_word(w);
      end
      if (!cmd_valid || !cmd_stall) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_valid <= 1'b1;
          mode <= words_to_send[0].mode;
          byte_value <= words_to_send[0].value;
          text_start <= words_to_send[0].start;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    pin_phase_t due;
    if (rst) begin
      pin_stall <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (pin_valid && !pin_stall) begin
        if (pin_phases_due.size() == 0) begin
          mismatches++;
          $display("%0t: phase expected none, got nibble %0h rs %0b en %0b hold %0h last %0b",
                   $time, nibble, reg_select, enable, hold_ticks, last);
        end else begin
          due = pin_phases_due.pop_front();
          check_field("nibble", due.nib, nibble);
          check_field("reg_select", due.rs, reg_select);
          check_field("enable", due.en, enable);
          check_field("hold_ticks", due.hold, hold_ticks);
          check_field("last", due.last, last);
        end
      end
      pin_stall <= ($urandom_range(99) < recv_stall_pct);
      if ((pin_valid && !pin_stall) || (cmd_valid && !cmd_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [15:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_PULSE: pulse_cfg = data;
      REG_SETTLE: settle_cfg = data;
      REG_LINE_LEN: line_len_cfg = data[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send(mode_t m, logic [7:0] value, logic start);
    words_to_send.push_back('{m, value, start});
  endtask

  task automatic wait_until_idle();
    while (words_to_send.size() != 0 || cmd_valid || pin_phases_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic lcd_word_t random_word();
    lcd_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.value = 8'($urandom);
    w.start = 1'($urandom);
    if (pick < 55) begin
      w.mode = MODE_CHAR;
      w.start = ($urandom_range(11) == 0);
    end else if (pick < 80) begin
      w.mode = MODE_COMMAND;
    end else if (pick < 90) begin
      w.mode = MODE_POWER;
    end else begin
      w.mode = MODE_NONE;
    end
    return w;
  endfunction

  task automatic run_random(int idle_pct, int stall_pct, logic [15:0] line_word);
    write_reg(REG_PULSE, 16'($urandom_range(65535, 1)));
    write_reg(REG_SETTLE, 16'($urandom_range(65535, 0)));
    write_reg(REG_LINE_LEN, line_word);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_WORDS / 2; i++) words_to_send.push_back(random_word());
    wait_until_idle();
    for (int i = RANDOM_WORDS / 2; i < RANDOM_WORDS; i++) words_to_send.push_back(random_word());
    wait_until_idle();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send(MODE_COMMAND, 8'h00, 1'b1);
    send(MODE_COMMAND, 8'hFF, 1'b0);
    send(MODE_POWER, 8'hA5, 1'b1);
    send(MODE_NONE, 8'hFF, 1'b1);
    send(MODE_CHAR, 8'h00, 1'b1);
    send(MODE_CHAR, 8'hFF, 1'b0);
    for (int i = 0; i < 14; i++) send(MODE_CHAR, 8'h41 + 8'(i), 1'b0);
    wait_until_idle();

    write_reg(REG_PULSE, 16'hFFFF);
    write_reg(REG_SETTLE, 16'hFFFF);
    write_reg(REG_LINE_LEN, 16'd1);
    send(MODE_POWER, 8'h00, 1'b0);
    send(MODE_CHAR, 8'h7E, 1'b1);
    send(MODE_CHAR, 8'h81, 1'b0);
    wait_until_idle();

    write_reg(REG_PULSE, 16'd1);
    write_reg(REG_SETTLE, 16'd0);
    write_reg(REG_LINE_LEN, 16'hFF80);
    write_reg(REG_SPARE, 16'($urandom));
    send(MODE_CHAR, 8'h20, 1'b1);
    send(MODE_NONE, 8'h00, 1'b0);
    send(MODE_COMMAND, 8'h5A, 1'b1);
    wait_until_idle();

    run_random(0, 0, 16'hFF90);
    run_random(50, 0, 16'($urandom_range(8, 1)));
    run_random(0, 50, 16'hFF80);
    run_random(22, 22, 16'hFFC0);
    write_reg(REG_SPARE, 16'($urandom));
    run_random(22, 22, 16'($urandom_range(64, 1)));

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/lcdn_pkg.sv
sv/lcdn_sequencer.sv
sv/lcd_nibble_write_sequencer.sv
tb/lcd_nibble_write_sequencer_tb.sv
